FILE: sv/bvr_pkg.sv
package bvr_pkg;

    // Field and register widths
    localparam int MV_W     = 15;
    localparam int HZ_W     = 18;
    localparam int ERR_W    = 8;
    localparam int IDX_W    = 2;
    localparam int CFG_W    = 18;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;

    // Signed working width for setpoint arithmetic (covers -400 .. 32927)
    localparam int SW_W = MV_W + 2;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_FLOOR_BRIDGE = 2'd0;
    localparam logic [IDX_W-1:0] REG_TOP_BRIDGE   = 2'd1;
    localparam logic [IDX_W-1:0] REG_FLOOR_SWITCH = 2'd2;
    localparam logic [IDX_W-1:0] REG_TOP_SWITCH   = 2'd3;

    // Command codes
    localparam logic CMD_SUPPLY = 1'b0;
    localparam logic CMD_ERROR  = 1'b1;

    // Reset values
    localparam logic [MV_W-1:0] RST_FLOOR_BRIDGE  = 15'd3000;
    localparam logic [MV_W-1:0] RST_TOP_BRIDGE    = 15'd12000;
    localparam logic [HZ_W-1:0] RST_FLOOR_SWITCH  = 18'd110000;
    localparam logic [HZ_W-1:0] RST_TOP_SWITCH    = 18'd148000;
    localparam logic [MV_W-1:0] NOMINAL_BRIDGE_MV = 15'd5000;
    localparam logic [HZ_W-1:0] NOMINAL_SWITCH_HZ = 18'd127000;

    // Regulation constants
    localparam logic signed [SW_W-1:0] BRIDGE_STEP   = 17'sd80;
    localparam logic signed [SW_W-1:0] BRIDGE_STEP_BIG = 17'sd160;
    localparam logic signed [SW_W-1:0] SUPPLY_MARGIN = 17'sd400;
    localparam logic [HZ_W:0]          SWITCH_STEP   = 19'd400;
    localparam logic signed [ERR_W-1:0] BIG_ERROR    = 8'sd3;

    // One input beat
    typedef struct packed {
        logic                    command;
        logic [MV_W-1:0]         supply_mv;
        logic signed [ERR_W-1:0] error_value;
    } item_t;

    // One result beat
    typedef struct packed {
        logic [MV_W-1:0] bridge_mv_out;
        logic [MV_W-1:0] ceiling_mv_out;
        logic [HZ_W-1:0] switch_hz_out;
        logic            at_limit;
    } result_t;

    // Handshake control between stages
    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;

endpackage

FILE: sv/bvr_in_stage.sv
// Input register: holds one accepted beat until the core takes it
module bvr_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  bvr_pkg::item_t in_item,
    output bvr_pkg::hs_t   fwd,
    input  logic           take,
    output bvr_pkg::item_t item
);

    logic           valid_reg;
    logic           valid_next;
    bvr_pkg::item_t item_reg;

    // Free slot, or the held beat moves on this cycle
    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign fwd.valid = valid_reg;
    assign fwd.ready = in_ready;
    assign item      = item_reg;

endmodule

FILE: sv/bvr_core.sv
// Configuration registers, regulator state and the one-step update
module bvr_core
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [bvr_pkg::IDX_W-1:0]  wr_index,
    input  logic [bvr_pkg::CFG_W-1:0]  wr_data,
    input  logic                       step_en,
    input  bvr_pkg::item_t             item,
    output bvr_pkg::result_t           result
);

    logic [bvr_pkg::MV_W-1:0] floor_bridge_reg;
    logic [bvr_pkg::MV_W-1:0] top_bridge_reg;
    logic [bvr_pkg::HZ_W-1:0] floor_switch_reg;
    logic [bvr_pkg::HZ_W-1:0] top_switch_reg;

    logic [bvr_pkg::MV_W-1:0] bridge_reg;
    logic [bvr_pkg::MV_W-1:0] bridge_next;
    logic [bvr_pkg::MV_W-1:0] ceiling_reg;
    logic [bvr_pkg::MV_W-1:0] ceiling_next;
    logic [bvr_pkg::HZ_W-1:0] switch_reg;
    logic [bvr_pkg::HZ_W-1:0] switch_next;
    logic                     limit_reg;
    logic                     limit_next;

    logic signed [bvr_pkg::SW_W-1:0] floor_s;
    logic signed [bvr_pkg::SW_W-1:0] top_s;
    logic signed [bvr_pkg::SW_W-1:0] bridge_s;
    logic signed [bvr_pkg::SW_W-1:0] ceiling_s;
    logic signed [bvr_pkg::SW_W-1:0] lim_s;
    logic signed [bvr_pkg::SW_W-1:0] step_s;
    logic signed [bvr_pkg::SW_W-1:0] up_s;
    logic signed [bvr_pkg::SW_W-1:0] dn_s;
    logic                            big_err;
    logic                            err_pos;
    logic                            err_neg;
    logic [bvr_pkg::HZ_W:0]          switch_up;
    logic [bvr_pkg::HZ_W:0]          floor_sw_up;

    // Configuration writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_bridge_reg <= bvr_pkg::RST_FLOOR_BRIDGE;
            top_bridge_reg   <= bvr_pkg::RST_TOP_BRIDGE;
            floor_switch_reg <= bvr_pkg::RST_FLOOR_SWITCH;
            top_switch_reg   <= bvr_pkg::RST_TOP_SWITCH;
        end
        else if (wr_en)
        begin
            case (wr_index)
                bvr_pkg::REG_FLOOR_BRIDGE: floor_bridge_reg <= wr_data[bvr_pkg::MV_W-1:0];
                bvr_pkg::REG_TOP_BRIDGE:   top_bridge_reg   <= wr_data[bvr_pkg::MV_W-1:0];
                bvr_pkg::REG_FLOOR_SWITCH: floor_switch_reg <= wr_data[bvr_pkg::HZ_W-1:0];
                bvr_pkg::REG_TOP_SWITCH:   top_switch_reg   <= wr_data[bvr_pkg::HZ_W-1:0];
                default: ;
            endcase
        end
    end

    // Signed views of the millivolt values
    assign floor_s   = $signed({2'b00, floor_bridge_reg});
    assign top_s     = $signed({2'b00, top_bridge_reg});
    assign bridge_s  = $signed({2'b00, bridge_reg});
    assign ceiling_s = $signed({2'b00, ceiling_reg});

    // Supply path: ceiling = supply - margin, top clamp then floor clamp
    always_comb
    begin
        lim_s = $signed({2'b00, item.supply_mv}) - bvr_pkg::SUPPLY_MARGIN;
        if (lim_s > top_s)
        begin
            lim_s = top_s;
        end
        if (lim_s < floor_s)
        begin
            lim_s = floor_s;
        end
    end

    // Error path: step size and both candidate setpoints
    assign err_pos = item.error_value > 8'sd0;
    assign err_neg = item.error_value < 8'sd0;
    assign big_err = (item.error_value > bvr_pkg::BIG_ERROR) ||
                     (item.error_value < -bvr_pkg::BIG_ERROR);
    assign step_s  = big_err ? bvr_pkg::BRIDGE_STEP_BIG : bvr_pkg::BRIDGE_STEP;
    assign up_s    = bridge_s + step_s;
    assign dn_s    = bridge_s - step_s;

    assign switch_up   = {1'b0, switch_reg} + bvr_pkg::SWITCH_STEP;
    assign floor_sw_up = {1'b0, floor_switch_reg} + bvr_pkg::SWITCH_STEP;

    // Next state
    always_comb
    begin
        bridge_next  = bridge_reg;
        ceiling_next = ceiling_reg;
        switch_next  = switch_reg;
        limit_next   = limit_reg;
        if (item.command == bvr_pkg::CMD_SUPPLY)
        begin
            ceiling_next = lim_s[bvr_pkg::MV_W-1:0];
            if (bridge_s > lim_s)
            begin
                bridge_next = lim_s[bvr_pkg::MV_W-1:0];
            end
        end
        else
        begin
            limit_next = 1'b0;
            if (err_pos)
            begin
                bridge_next = up_s[bvr_pkg::MV_W-1:0];
                if (up_s >= ceiling_s)
                begin
                    bridge_next = ceiling_reg;
                    limit_next  = 1'b1;
                    if ({1'b0, switch_reg} > floor_sw_up)
                    begin
                        switch_next = switch_reg - bvr_pkg::SWITCH_STEP[bvr_pkg::HZ_W-1:0];
                    end
                end
            end
            else if (err_neg)
            begin
                bridge_next = dn_s[bvr_pkg::MV_W-1:0];
                if (dn_s <= floor_s)
                begin
                    bridge_next = floor_bridge_reg;
                    limit_next  = 1'b1;
                    if (switch_up <= {1'b0, top_switch_reg})
                    begin
                        switch_next = switch_up[bvr_pkg::HZ_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bridge_reg  <= bvr_pkg::NOMINAL_BRIDGE_MV;
            ceiling_reg <= bvr_pkg::RST_TOP_BRIDGE;
            switch_reg  <= bvr_pkg::NOMINAL_SWITCH_HZ;
            limit_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            bridge_reg  <= bridge_next;
            ceiling_reg <= ceiling_next;
            switch_reg  <= switch_next;
            limit_reg   <= limit_next;
        end
    end

    assign result.bridge_mv_out  = bridge_next;
    assign result.ceiling_mv_out = ceiling_next;
    assign result.switch_hz_out  = switch_next;
    assign result.at_limit       = limit_next;

endmodule

FILE: sv/bvr_out_stage.sv
// Result register: holds a finished beat until the sink takes it
module bvr_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  bvr_pkg::result_t result,
    output bvr_pkg::hs_t     st,
    input  logic             out_ready,
    output bvr_pkg::result_t out_result
);

    logic             valid_reg;
    logic             valid_next;
    bvr_pkg::result_t result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    // Can take a new beat when empty or draining this cycle
    assign st.valid   = valid_reg;
    assign st.ready   = !valid_reg || out_ready;
    assign out_result = result_reg;

endmodule

FILE: sv/bridge_voltage_error_regulator.sv
// Bridge voltage regulator driven by supply readings and control error
// values. Each input beat yields exactly one result beat carrying the bridge
// setpoint, its ceiling, the inverter switching frequency and the limit flag.
// A beat passes an input register, add/compare logic that also updates the
// regulator state, and a result register; one beat is accepted every cycle
// while the sink keeps taking results. The state update (setpoint, ceiling,
// frequency, flag), made in the same cycle the beat enters the result
// register, is what sets this rate. Registers must be written by the user
// through wr_en/wr_index/wr_data while no beat is in flight; not enforced.
module bridge_voltage_error_regulator
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port
    input  logic                              wr_en,
    input  logic [bvr_pkg::IDX_W-1:0]         wr_index,
    input  logic [bvr_pkg::CFG_W-1:0]         wr_data,
    // Input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [bvr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // supply_mv[14:0], error_value[22:15]
    input  logic                              s_axis_tuser,  // command
    // Result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [bvr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // bridge_mv_out[14:0],
                                                             // ceiling_mv_out[29:15],
                                                             // switch_hz_out[47:30]
    output logic                              m_axis_tuser   // at_limit
);

    bvr_pkg::item_t   in_item;
    bvr_pkg::item_t   item;
    bvr_pkg::hs_t     in_hs;
    bvr_pkg::hs_t     out_hs;
    bvr_pkg::result_t result;
    bvr_pkg::result_t out_result;
    logic             step_en;

    // Unpack the input beat
    assign in_item.command     = s_axis_tuser;
    assign in_item.supply_mv   = s_axis_tdata[14:0];
    assign in_item.error_value = $signed(s_axis_tdata[22:15]);

    // Held beat moves into the result register
    assign step_en = in_hs.valid && out_hs.ready;

    bvr_in_stage u_in
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .fwd      (in_hs),
        .take     (step_en),
        .item     (item)
    );

    bvr_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .step_en  (step_en),
        .item     (item),
        .result   (result)
    );

    bvr_out_stage u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step_en),
        .result     (result),
        .st         (out_hs),
        .out_ready  (m_axis_tready),
        .out_result (out_result)
    );

    // Pack the result beat
    assign m_axis_tvalid = out_hs.valid;
    assign m_axis_tdata  = {out_result.switch_hz_out,
                            out_result.ceiling_mv_out,
                            out_result.bridge_mv_out};
    assign m_axis_tuser  = out_result.at_limit;

endmodule

FILE: sv/bvr_checker.sv
// Port-level checks for the regulator
module bvr_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [bvr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tuser
);

    // A stalled result beat stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // A sink that takes results never backs up the input side
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while sink ready");

    // No result beat straight out of reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Two-stage pipeline: a result cannot appear without an earlier input beat
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready || s_axis_tvalid, 2) ||
                                 $past(!s_axis_tready, 1))
        else $error("result beat without input");

endmodule

bind bridge_voltage_error_regulator bvr_checker u_bvr_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/tb_bridge_voltage_error_regulator.sv
`timescale 1ns / 1ps

module tb_bridge_voltage_error_regulator;

    localparam int STEP_MV          = 80;
    localparam int BIG_STEP_MV      = 160;
    localparam int MARGIN_MV        = 400;
    localparam int STEP_HZ          = 400;
    localparam int BIG_ERR_LEVEL    = 3;
    localparam int DRAIN_CYCLES     = 10;
    localparam int SINK_HOLD_CYCLES = 200;
    localparam int PHASES           = 6;
    localparam int MAX_REPORTS      = 10;
    localparam int HOLD_AT_BEAT     = 30;

    // One row of the directed table; want is used only when typed is set
    typedef struct packed {
        logic                             cmd;
        logic [bvr_pkg::MV_W-1:0]         supply_mv;
        logic [bvr_pkg::ERR_W-1:0]        err;
        logic                             typed;
        bvr_pkg::result_t                 want;
    } row_t;

    logic                              clk;
    logic                              rst_n;
    logic                              wr_en;
    logic [bvr_pkg::IDX_W-1:0]         wr_index;
    logic [bvr_pkg::CFG_W-1:0]         wr_data;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [bvr_pkg::IN_TDATA_W-1:0]    s_axis_tdata;
    logic                              s_axis_tuser;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic [bvr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;
    logic                              m_axis_tuser;

    // Regulator state and register copies kept by the predictor
    int set_mv;
    int ceil_mv;
    int sw_hz;
    bit sat_flag;
    int cfg_floor_mv;
    int cfg_top_mv;
    int cfg_floor_hz;
    int cfg_top_hz;

    bvr_pkg::result_t expected_q[$];
    row_t             dir_rows[$];

    int idle_pct;
    bit sink_hold_req;
    int run_left;
    bit run_up;

    int mismatches;
    int supply_beats;
    int error_beats;
    int limit_results;
    int hz_steps;
    int settings_used;

    bridge_voltage_error_regulator i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Predicts the result of one beat and advances the regulator state
    function automatic bvr_pkg::result_t regulate_beat(
        input logic                     cmd,
        input logic [bvr_pkg::MV_W-1:0] supply_mv,
        input int                       err);
        int               lim;
        int               step;
        int               hz_was;
        bvr_pkg::result_t r;
        hz_was = sw_hz;
        if (cmd == bvr_pkg::CMD_SUPPLY)
        begin
            supply_beats++;
            // signed difference; top clamp first, floor clamp last
            lim = int'(supply_mv) - MARGIN_MV;
            if (lim > cfg_top_mv)
                lim = cfg_top_mv;
            if (lim < cfg_floor_mv)
                lim = cfg_floor_mv;
            ceil_mv = lim;
            if (set_mv > ceil_mv)
                set_mv = ceil_mv;
        end
        else
        begin
            error_beats++;
            sat_flag = 1'b0;
            step = (err > BIG_ERR_LEVEL || err < -BIG_ERR_LEVEL) ? BIG_STEP_MV : STEP_MV;
            if (err > 0)
            begin
                set_mv = set_mv + step;
                if (set_mv >= ceil_mv)
                begin
                    set_mv   = ceil_mv;
                    sat_flag = 1'b1;
                    if (sw_hz > cfg_floor_hz + STEP_HZ)
                        sw_hz = sw_hz - STEP_HZ;
                end
            end
            else if (err < 0)
            begin
                set_mv = set_mv - step;
                if (set_mv <= cfg_floor_mv)
                begin
                    set_mv   = cfg_floor_mv;
                    sat_flag = 1'b1;
                    if (sw_hz + STEP_HZ <= cfg_top_hz)
                        sw_hz = sw_hz + STEP_HZ;
                end
            end
            if (sat_flag)
                limit_results++;
        end
        if (sw_hz != hz_was)
            hz_steps++;
        r.bridge_mv_out  = set_mv[bvr_pkg::MV_W-1:0];
        r.ceiling_mv_out = ceil_mv[bvr_pkg::MV_W-1:0];
        r.switch_hz_out  = sw_hz[bvr_pkg::HZ_W-1:0];
        r.at_limit       = sat_flag;
        return r;
    endfunction

    // Idle length: mostly none, sometimes short, rarely long
    function automatic int pick_gap();
        if (idle_pct == 0 || $urandom_range(0, 99) >= idle_pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic void add_row(input logic cmd, input int supply_mv, input int err,
                                    input bit typed, input int b_mv, input int c_mv,
                                    input int hz, input bit flag);
        row_t r;
        r.cmd                 = cmd;
        r.supply_mv           = supply_mv[bvr_pkg::MV_W-1:0];
        r.err                 = err[bvr_pkg::ERR_W-1:0];
        r.typed               = typed;
        r.want.bridge_mv_out  = b_mv[bvr_pkg::MV_W-1:0];
        r.want.ceiling_mv_out = c_mv[bvr_pkg::MV_W-1:0];
        r.want.switch_hz_out  = hz[bvr_pkg::HZ_W-1:0];
        r.want.at_limit       = flag;
        dir_rows.push_back(r);
    endfunction

    // Offer one beat and hold it until the block takes it
    task automatic drive_beat(input logic cmd, input logic [bvr_pkg::MV_W-1:0] supply_mv,
                              input logic [bvr_pkg::ERR_W-1:0] err_bits);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {1'b0, err_bits, supply_mv};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic pause_source(input int n);
        if (n == 0)
            return;
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Stop sending and wait until every pending result has come out
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all four registers while the block is idle
    task automatic apply_settings(input int f_mv, input int t_mv, input int f_hz, input int t_hz);
        logic [bvr_pkg::IDX_W-1:0] idx;
        logic [bvr_pkg::CFG_W-1:0] word;
        int                        noise;
        settle();
        for (int k = 0; k < 4; k++)
        begin
            idx   = k[bvr_pkg::IDX_W-1:0];
            // spare upper bits of the voltage registers carry noise
            noise = $urandom;
            word  = noise[bvr_pkg::CFG_W-1:0];
            case (idx)
                bvr_pkg::REG_FLOOR_BRIDGE:
                begin
                    word[bvr_pkg::MV_W-1:0] = f_mv[bvr_pkg::MV_W-1:0];
                    cfg_floor_mv            = int'(word[bvr_pkg::MV_W-1:0]);
                end
                bvr_pkg::REG_TOP_BRIDGE:
                begin
                    word[bvr_pkg::MV_W-1:0] = t_mv[bvr_pkg::MV_W-1:0];
                    cfg_top_mv              = int'(word[bvr_pkg::MV_W-1:0]);
                end
                bvr_pkg::REG_FLOOR_SWITCH:
                begin
                    word         = f_hz[bvr_pkg::CFG_W-1:0];
                    cfg_floor_hz = int'(word);
                end
                default:
                begin
                    word       = t_hz[bvr_pkg::CFG_W-1:0];
                    cfg_top_hz = int'(word);
                end
            endcase
            wr_en    <= 1'b1;
            wr_index <= idx;
            wr_data  <= word;
            @(posedge clk);
        end
        wr_en <= 1'b0;
        settings_used++;
    endtask

    // Mostly runs of same-sign errors to walk into the limits, some supply beats and noise
    task automatic random_beat(output logic cmd, output logic [bvr_pkg::MV_W-1:0] supply_mv,
                               output int err);
        int mag;
        int pick;
        int raw;
        raw       = $urandom;
        supply_mv = raw[bvr_pkg::MV_W-1:0];
        err       = int'($urandom_range(0, 255)) - 128;
        pick      = $urandom_range(0, 99);
        if (pick < 20)
        begin
            cmd = bvr_pkg::CMD_SUPPLY;
            case ($urandom_range(0, 3))
                0, 1: raw = $urandom_range(0, 32767);
                2: raw = $urandom_range(0, 800);
                default: raw = $urandom_range(2500, 13000);
            endcase
            supply_mv = raw[bvr_pkg::MV_W-1:0];
        end
        else
        begin
            cmd = bvr_pkg::CMD_ERROR;
            if (run_left == 0)
            begin
                run_left = $urandom_range(5, 30);
                run_up   = $urandom_range(0, 1);
            end
            run_left--;
            pick = $urandom_range(0, 99);
            if (pick < 5)
                err = 0;
            else if (pick >= 15)
            begin
                mag = ($urandom_range(0, 99) < 40) ? $urandom_range(1, 3) : $urandom_range(4, 127);
                err = run_up ? mag : -mag;
                if (!run_up && $urandom_range(0, 15) == 0)
                    err = -128;
            end
        end
    endtask

    // Result sink: random stalls, plus one long hold on request
    initial
    begin : sink_side
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (sink_hold_req)
            begin
                sink_hold_req = 1'b0;
                stall_left    = SINK_HOLD_CYCLES;
            end
            if (stall_left != 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Compare each result beat with the oldest pending prediction
    always @(posedge clk)
    begin : result_check
        bvr_pkg::result_t got;
        bvr_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.bridge_mv_out  = m_axis_tdata[bvr_pkg::MV_W-1:0];
            got.ceiling_mv_out = m_axis_tdata[2*bvr_pkg::MV_W-1:bvr_pkg::MV_W];
            got.switch_hz_out  = m_axis_tdata[2*bvr_pkg::MV_W+bvr_pkg::HZ_W-1:2*bvr_pkg::MV_W];
            got.at_limit       = m_axis_tuser;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected beat bridge %0d ceiling %0d hz %0d limit %0b",
                             $time, got.bridge_mv_out, got.ceiling_mv_out, got.switch_hz_out,
                             got.at_limit);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.bridge_mv_out !== want.bridge_mv_out
                    || got.ceiling_mv_out !== want.ceiling_mv_out
                    || got.switch_hz_out !== want.switch_hz_out
                    || got.at_limit !== want.at_limit)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"%0t: mismatch exp/act bridge %0d/%0d ceiling %0d/%0d",
                                  " hz %0d/%0d limit %0b/%0b"},
                                 $time, want.bridge_mv_out, got.bridge_mv_out,
                                 want.ceiling_mv_out, got.ceiling_mv_out,
                                 want.switch_hz_out, got.switch_hz_out,
                                 want.at_limit, got.at_limit);
                end
            end
        end
    end

    // Main stimulus
    initial
    begin : stimulus
        row_t                     row;
        bvr_pkg::result_t         predicted;
        logic                     cmd;
        logic [bvr_pkg::MV_W-1:0] supply_mv;
        int                       err;
        int                       beats;
        int                       fmv;
        int                       fhz;

        rst_n         <= 1'b0;
        wr_en         <= 1'b0;
        wr_index      <= bvr_pkg::REG_FLOOR_BRIDGE;
        wr_data       <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= bvr_pkg::CMD_SUPPLY;

        set_mv        = int'(bvr_pkg::NOMINAL_BRIDGE_MV);
        ceil_mv       = int'(bvr_pkg::RST_TOP_BRIDGE);
        sw_hz         = int'(bvr_pkg::NOMINAL_SWITCH_HZ);
        sat_flag      = 1'b0;
        cfg_floor_mv  = int'(bvr_pkg::RST_FLOOR_BRIDGE);
        cfg_top_mv    = int'(bvr_pkg::RST_TOP_BRIDGE);
        cfg_floor_hz  = int'(bvr_pkg::RST_FLOOR_SWITCH);
        cfg_top_hz    = int'(bvr_pkg::RST_TOP_SWITCH);
        idle_pct      = 30;
        sink_hold_req = 1'b0;
        run_left      = 0;
        run_up        = 1'b0;
        mismatches    = 0;
        supply_beats  = 0;
        error_beats   = 0;
        limit_results = 0;
        hz_steps      = 0;
        settings_used = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under reset settings
        add_row(bvr_pkg::CMD_ERROR, 0, 0, 1, 5000, 12000, 127000, 0);   // zero error after reset
        add_row(bvr_pkg::CMD_ERROR, 0, 1, 0, 0, 0, 0, 0);
        add_row(bvr_pkg::CMD_ERROR, 0, 3, 0, 0, 0, 0, 0);
        add_row(bvr_pkg::CMD_ERROR, 0, 4, 0, 0, 0, 0, 0);               // first big step
        add_row(bvr_pkg::CMD_ERROR, 0, -1, 0, 0, 0, 0, 0);
        add_row(bvr_pkg::CMD_ERROR, 0, -3, 0, 0, 0, 0, 0);
        add_row(bvr_pkg::CMD_ERROR, 0, -4, 0, 0, 0, 0, 0);
        add_row(bvr_pkg::CMD_ERROR, 0, 127, 0, 0, 0, 0, 0);
        add_row(bvr_pkg::CMD_ERROR, 0, -128, 0, 0, 0, 0, 0);
        add_row(bvr_pkg::CMD_SUPPLY, 32767, 0, 1, 5000, 12000, 127000, 0); // top clamp
        add_row(bvr_pkg::CMD_SUPPLY, 5200, 0, 0, 0, 0, 0, 0);           // setpoint pulled down
        add_row(bvr_pkg::CMD_ERROR, 0, 5, 0, 0, 0, 0, 0);               // hits ceiling
        add_row(bvr_pkg::CMD_SUPPLY, 0, 0, 1, 3000, 3000, 126600, 1);   // negative, to floor
        add_row(bvr_pkg::CMD_SUPPLY, 399, 0, 0, 0, 0, 0, 0);
        add_row(bvr_pkg::CMD_SUPPLY, 400, 0, 0, 0, 0, 0, 0);
        add_row(bvr_pkg::CMD_ERROR, 0, -2, 0, 0, 0, 0, 0);              // hits floor
        add_row(bvr_pkg::CMD_ERROR, 0, 0, 0, 0, 0, 0, 0);               // only clears the flag
        add_row(bvr_pkg::CMD_SUPPLY, 12400, 0, 0, 0, 0, 0, 0);
        add_row(bvr_pkg::CMD_SUPPLY, 12401, 0, 0, 0, 0, 0, 0);
        add_row(bvr_pkg::CMD_SUPPLY, 12399, 0, 0, 0, 0, 0, 0);
        add_row(bvr_pkg::CMD_ERROR, 32767, -128, 0, 0, 0, 0, 0);        // unused supply bits set
        add_row(bvr_pkg::CMD_SUPPLY, 9000, -1, 0, 0, 0, 0, 0);          // unused error bits set
        add_row(bvr_pkg::CMD_ERROR, 0, 127, 0, 0, 0, 0, 0);

        foreach (dir_rows[n])
        begin
            row = dir_rows[n];
            drive_beat(row.cmd, row.supply_mv, row.err);
            predicted = regulate_beat(row.cmd, row.supply_mv, int'($signed(row.err)));
            expected_q.push_back(row.typed ? row.want : predicted);
            pause_source(pick_gap());
        end

        // Random phases, each under its own register settings
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    apply_settings(0, 32767, 0, 262143);          // widest bounds
                    idle_pct = 40;
                    beats    = 100;
                end
                1:
                begin
                    apply_settings(32767, 0, 262143, 0);          // floor above top, hz blocked
                    idle_pct = 20;
                    beats    = 60;
                end
                2:
                begin
                    apply_settings(8000, 20000, 126800, 127600);  // raised floor, narrow hz band
                    idle_pct = 60;
                    beats    = 80;
                end
                3:
                begin
                    apply_settings(int'(bvr_pkg::RST_FLOOR_BRIDGE),
                                   int'(bvr_pkg::RST_TOP_BRIDGE),
                                   int'(bvr_pkg::RST_FLOOR_SWITCH),
                                   int'(bvr_pkg::RST_TOP_SWITCH));
                    idle_pct = 0;
                    beats    = 80;
                end
                4:
                begin
                    fmv = $urandom_range(0, 8000);
                    fhz = $urandom_range(0, 200000);
                    apply_settings(fmv, fmv + $urandom_range(0, 20000),
                                   fhz, fhz + $urandom_range(0, 60000));
                    idle_pct = 30;
                    beats    = 90;
                end
                default:
                begin
                    apply_settings($urandom_range(0, 32767), $urandom_range(0, 32767),
                                   $urandom_range(0, 262143), $urandom_range(0, 262143));
                    idle_pct = 50;
                    beats    = 90;
                end
            endcase
            for (int n = 0; n < beats; n++)
            begin
                // sink holds off while beats keep coming
                if (p == 0 && n == HOLD_AT_BEAT)
                    sink_hold_req = 1'b1;
                random_beat(cmd, supply_mv, err);
                drive_beat(cmd, supply_mv, err[bvr_pkg::ERR_W-1:0]);
                expected_q.push_back(regulate_beat(cmd, supply_mv, err));
                pause_source(pick_gap());
            end
        end

        settle();
        $display("Covered %0d supply and %0d error beats over %0d register settings.",
                 supply_beats, error_beats, settings_used + 1);
        $display("%0d results at a limit, %0d switching frequency steps, %0d mismatches.",
                 limit_results, hz_steps, mismatches);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
